### rtl/bht_pkg.sv
// shared types, codes and default sizes of the bucketed hash table
package bht_pkg;

    // default sizes
    localparam int BUCKETS_DEF    = 2048;
    localparam int WAYS_DEF       = 4;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // fixed port widths
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 14;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } state_t;

    // control from the bucket update logic to the sequencer
    typedef struct packed {
        logic    row_we;
        logic    fill_we;
        logic    cnt_inc;
        logic    cnt_dec;
        status_t status;
    } upd_ctl_t;

endpackage

### rtl/bht_ram.sv
// generic single-port-write, registered-read ram
module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bht_update.sv
// bucket row compare, shift and append logic for one operation
module bht_update
    import bht_pkg::*;
#(
    parameter int WAYS       = WAYS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int ROW_W     = WAYS * (KEY_BITS + VALUE_BITS),
    localparam int FILL_W    = $clog2(WAYS + 1)
) (
    input  logic [KIND_W-1:0]     kind,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [ROW_W-1:0]      row_rdata,
    input  logic [FILL_W-1:0]     fill,
    output logic [ROW_W-1:0]      row_wdata,
    output logic [FILL_W-1:0]     fill_wdata,
    output logic [VALUE_W-1:0]    found_value,
    output upd_ctl_t              ctl
);

    localparam int VAL_OFS = WAYS * KEY_BITS;

    logic [KEY_BITS-1:0]   keys     [WAYS];
    logic [VALUE_BITS-1:0] vals     [WAYS];
    logic [KEY_BITS-1:0]   keys_new [WAYS];
    logic [VALUE_BITS-1:0] vals_new [WAYS];
    logic                  hit;
    int                    slot;

    // oldest valid way with an equal key
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            keys[i] = row_rdata[i*KEY_BITS +: KEY_BITS];
            vals[i] = row_rdata[VAL_OFS + i*VALUE_BITS +: VALUE_BITS];
        end
        hit  = 1'b0;
        slot = 0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (i < int'(fill) && keys[i] == key) begin
                hit  = 1'b1;
                slot = i;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            keys_new[i] = keys[i];
            vals_new[i] = vals[i];
        end
        fill_wdata  = fill;
        found_value = '0;
        ctl         = '{row_we: 1'b0, fill_we: 1'b0, cnt_inc: 1'b0, cnt_dec: 1'b0,
                        status: STS_OK};
        unique case (kind)
            OP_INSERT: begin
                if (int'(fill) >= WAYS) begin
                    ctl.status = STS_FULL;
                end else begin
                    // append at the first free way
                    for (int i = 0; i < WAYS; i++) begin
                        if (i == int'(fill)) begin
                            keys_new[i] = key;
                            vals_new[i] = value;
                        end
                    end
                    fill_wdata  = FILL_W'(fill + 1'b1);
                    ctl.row_we  = 1'b1;
                    ctl.fill_we = 1'b1;
                    ctl.cnt_inc = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!hit) begin
                    ctl.status = STS_MISS;
                end else begin
                    // later entries move up one way
                    for (int i = 0; i < WAYS - 1; i++) begin
                        if (i >= slot) begin
                            keys_new[i] = keys[i+1];
                            vals_new[i] = vals[i+1];
                        end
                    end
                    fill_wdata  = FILL_W'(fill - 1'b1);
                    ctl.row_we  = 1'b1;
                    ctl.fill_we = 1'b1;
                    ctl.cnt_dec = 1'b1;
                end
            end
            OP_FIND: begin
                if (!hit) begin
                    ctl.status = STS_MISS;
                end else begin
                    for (int i = 0; i < WAYS; i++) begin
                        if (i == slot) begin
                            found_value = VALUE_W'(vals[i]);
                        end
                    end
                end
            end
            default: begin
                // unused kind: no change
            end
        endcase
        for (int i = 0; i < WAYS; i++) begin
            row_wdata[i*KEY_BITS +: KEY_BITS]               = keys_new[i];
            row_wdata[VAL_OFS + i*VALUE_BITS +: VALUE_BITS] = vals_new[i];
        end
    end

endmodule

### rtl/bucketed_hash_table_core.sv
// top level of the bucketed hash table: sequencer, bucket memories, result register
// a request's bucket row and fill count are read into registered ram outputs, then compared and
// written back with the result registered; write-back waits until the result register is free;
// one request at a time, the next taken after write-back; a finished result waits in the output
// register while the next request is read; reset: aresetn synchronous active low, then a
// clearing pass over all buckets zeroes the fill counts, with s_ready low until it ends
module bucketed_hash_table_core
    import bht_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int WAYS       = WAYS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [KEY_W-1:0]     s_key,
    input  logic [VALUE_W-1:0]   s_value,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [VALUE_W-1:0]   m_found_value,
    output logic [ENTRIES_W-1:0] m_entries_in_use
);

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int ROW_W   = WAYS * (KEY_BITS + VALUE_BITS);
    localparam int FILL_W  = $clog2(WAYS + 1);
    localparam int CNT_MAX = BUCKETS * WAYS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // sequencer
    state_t state_reg, state_next;
    logic [BKT_W-1:0] clr_idx_reg, clr_idx_next;

    // captured request
    logic [KIND_W-1:0]     kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [BKT_W-1:0]      bkt_reg;

    // running entry count
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [VALUE_W-1:0]   m_found_value_reg;
    logic [ENTRIES_W-1:0] m_entries_reg;

    // memory ports
    logic              accept;
    logic              commit;
    logic [BKT_W-1:0]  rd_bkt;
    logic [ROW_W-1:0]  row_rdata, row_wdata;
    logic [FILL_W-1:0] fill_rdata, fill_wdata, fill_wr_data;
    logic [BKT_W-1:0]  fill_waddr;
    logic              fill_we;
    logic [VALUE_W-1:0] found_value;
    upd_ctl_t          ctl;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    // bucket is the low key bits
    assign rd_bkt  = s_key[BKT_W-1:0];
    // write-back happens once the result register is free
    assign commit  = (state_reg == S_LOOKUP) && (!m_valid_reg || m_ready);

    // bucket rows: keys then values of all ways, undefined until written
    bht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (commit && ctl.row_we),
        .waddr (bkt_reg),
        .wdata (row_wdata),
        .re    (accept),
        .raddr (rd_bkt),
        .rdata (row_rdata)
    );

    // per-bucket fill counts, zeroed by the clearing pass
    assign fill_we      = (state_reg == S_CLEAR) || (commit && ctl.fill_we);
    assign fill_waddr   = (state_reg == S_CLEAR) ? clr_idx_reg : bkt_reg;
    assign fill_wr_data = (state_reg == S_CLEAR) ? '0 : fill_wdata;

    bht_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS)
    ) u_fill_ram (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wr_data),
        .re    (accept),
        .raddr (rd_bkt),
        .rdata (fill_rdata)
    );

    // compare, shift and append on the row just read
    bht_update #(
        .WAYS       (WAYS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_update (
        .kind        (kind_reg),
        .key         (key_reg),
        .value       (value_reg),
        .row_rdata   (row_rdata),
        .fill        (fill_rdata),
        .row_wdata   (row_wdata),
        .fill_wdata  (fill_wdata),
        .found_value (found_value),
        .ctl         (ctl)
    );

    // next state and counters
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                clr_idx_next = BKT_W'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == BKT_W'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (commit) begin
                    if (ctl.cnt_inc) begin
                        cnt_next = CNT_W'(cnt_reg + 1'b1);
                    end else if (ctl.cnt_dec && cnt_reg != '0) begin
                        cnt_next = CNT_W'(cnt_reg - 1'b1);
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            key_reg   <= KEY_BITS'(s_key);
            value_reg <= VALUE_BITS'(s_value);
            bkt_reg   <= rd_bkt;
        end
        if (commit) begin
            m_status_reg      <= ctl.status;
            m_found_value_reg <= found_value;
            m_entries_reg     <= ENTRIES_W'(cnt_next);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_value    = m_found_value_reg;
    assign m_entries_in_use = m_entries_reg;

    // an accepted request always goes to the lookup step
    a_accept_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_LOOKUP)
        else $error("accepted request did not reach lookup");

    // a new result only comes out of a lookup
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_LOOKUP)
        else $error("result raised outside lookup");

    // entry count stays within the table size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CNT_MAX))
        else $error("entry count beyond table size");

    // no request is taken and no result is pending while the fill counts are being cleared
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !accept && !m_valid_reg)
        else $error("activity during clearing pass");

endmodule
